[src/msgs_pkg.sv]
package msgs_pkg;

   // default sizes
   localparam int MAX_STOPS  = 8;
   localparam int MAX_SPAN   = 64;
   localparam int COORD_BITS = 12;

   // stop entry layout
   localparam int POS_W = 17;
   localparam int COL_W = 32;
   localparam int ENT_W = POS_W + COL_W;
   localparam logic [POS_W-1:0] ONE_Q16 = 17'd65536;

   // weight divider
   localparam int W_W       = 17;
   localparam int REM_W     = 18;
   localparam int DIV_STEPS = 17;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SPAN,
      OP_MULY,
      OP_MULX,
      OP_ACCX,
      OP_CLAMP,
      OP_SCAN,
      OP_DIV,
      OP_MIX,
      OP_PROD,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic scan_div;
      logic div_done;
      logic out_free;
      logic span_end;
   } status_type;

endpackage

[src/msgs_ram.sv]
module msgs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
   input  logic [WIDTH-1:0]                 wdata,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
   output logic [WIDTH-1:0]                 rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

[src/msgs_ctrl.sv]
module msgs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_kind,
   input  logic [6:0]            req_span_length,
   input  msgs_pkg::status_type  status,
   output logic                  req_ready,
   output msgs_pkg::cmd_type     cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MULY,
      ST_MULX,
      ST_ACCX,
      ST_CLAMP,
      ST_SCAN,
      ST_DIV,
      ST_MIX,
      ST_PROD,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // command for the datapath
   always_comb begin
      unique case (state_ff)
         ST_IDLE:  cmd.op = !accept ? msgs_pkg::OP_NONE :
                            (req_kind ? msgs_pkg::OP_LOAD : msgs_pkg::OP_SPAN);
         ST_MULY:  cmd.op = msgs_pkg::OP_MULY;
         ST_MULX:  cmd.op = msgs_pkg::OP_MULX;
         ST_ACCX:  cmd.op = msgs_pkg::OP_ACCX;
         ST_CLAMP: cmd.op = msgs_pkg::OP_CLAMP;
         ST_SCAN:  cmd.op = msgs_pkg::OP_SCAN;
         ST_DIV:   cmd.op = msgs_pkg::OP_DIV;
         ST_MIX:   cmd.op = msgs_pkg::OP_MIX;
         ST_PROD:  cmd.op = msgs_pkg::OP_PROD;
         ST_EMIT:  cmd.op = msgs_pkg::OP_EMIT;
         default:  cmd.op = msgs_pkg::OP_NONE;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !req_kind && (req_span_length != 7'd0)) begin
               state_in = ST_MULY;
            end
         end
         ST_MULY:  state_in = ST_MULX;
         ST_MULX:  state_in = ST_ACCX;
         ST_ACCX:  state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_SCAN;
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = status.scan_div ? ST_DIV : ST_MIX;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_MIX;
            end
         end
         ST_MIX:   state_in = ST_PROD;
         ST_PROD:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = status.span_end ? ST_IDLE : ST_CLAMP;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/msgs_dpath.sv]
module msgs_dpath #(
   parameter int MAX_STOPS  = msgs_pkg::MAX_STOPS,
   parameter int MAX_SPAN   = msgs_pkg::MAX_SPAN,
   parameter int COORD_BITS = msgs_pkg::COORD_BITS,
   localparam int AW        = $clog2(MAX_STOPS > 1 ? MAX_STOPS : 2)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  msgs_pkg::cmd_type            cmd,
   output msgs_pkg::status_type         status,
   input  logic [COORD_BITS-1:0]        req_pixel_x,
   input  logic [COORD_BITS-1:0]        req_pixel_y,
   input  logic [6:0]                   req_span_length,
   input  logic [2:0]                   req_stop_index,
   input  logic [16:0]                  req_stop_position,
   input  logic [7:0]                   req_stop_red,
   input  logic [7:0]                   req_stop_green,
   input  logic [7:0]                   req_stop_blue,
   input  logic [7:0]                   req_stop_alpha,
   input  logic signed [31:0]           coef_x,
   input  logic signed [31:0]           coef_y,
   input  logic signed [39:0]           coef_offset,
   input  logic [3:0]                   stop_count,
   output logic                         ram_we,
   output logic [AW-1:0]                ram_waddr,
   output logic [msgs_pkg::ENT_W-1:0]   ram_wdata,
   output logic [AW-1:0]                ram_raddr,
   input  logic [msgs_pkg::ENT_W-1:0]   ram_rdata,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic [31:0]                  rsp_pixel,
   output logic                         rsp_last
);

   localparam int T_W = COORD_BITS + 36;
   localparam int C_W = COORD_BITS + 1;
   localparam int M_W = 32 + C_W + 1;

   logic [COORD_BITS-1:0]          x0_ff, y_ff;
   logic [6:0]                     cnt_ff;
   logic signed [T_W-1:0]          t_ff;
   logic signed [M_W-1:0]          mul_ff;
   logic [16:0]                    t16_ff;
   logic [AW-1:0]                  idx_ff, idx_in, last_idx;
   logic [16:0]                    prev_pos_ff;
   logic [31:0]                    prev_col_ff, cl_ff, cr_ff;
   logic [16:0]                    den_ff;
   logic [msgs_pkg::REM_W-1:0]     rem_ff;
   logic [msgs_pkg::W_W-1:0]       w_ff;
   logic [4:0]                     step_ff;
   logic [3:0][23:0]               ch_ff;
   logic [2:0][47:0]               prod_ff;
   logic                           rsp_valid_ff, rsp_last_ff;
   logic [31:0]                    rsp_pixel_ff;

   logic signed [31:0]             mul_a;
   logic [C_W-1:0]                 mul_b;
   logic signed [M_W-1:0]          product;
   logic [6:0]                     len_sat;
   logic [5:0]                     n_used;
   logic                           above, hit, at_last, div_ge, out_free, emit;
   logic [29:0]                    t_cl;
   logic [16:0]                    t16_in, r_pos;
   logic [31:0]                    r_col;
   logic [3:0][23:0]               ch_in;
   logic [31:0]                    pix_in;

   // stop load into the entry memory
   assign ram_we    = (cmd.op == msgs_pkg::OP_LOAD) && (32'(req_stop_index) < MAX_STOPS);
   assign ram_waddr = AW'(req_stop_index);
   assign ram_wdata = {(req_stop_position > msgs_pkg::ONE_Q16) ? msgs_pkg::ONE_Q16
                                                              : req_stop_position,
                       req_stop_alpha, req_stop_red, req_stop_green, req_stop_blue};

   // span length saturation and stops in use
   always_comb begin
      len_sat = (32'(req_span_length) > MAX_SPAN) ? 7'(MAX_SPAN) : req_span_length;
      if (stop_count < 4'd2) begin
         n_used = 6'd2;
      end else if (32'(stop_count) > MAX_STOPS) begin
         n_used = 6'(MAX_STOPS);
      end else begin
         n_used = 6'(stop_count);
      end
      last_idx = AW'(n_used - 6'd1);
   end

   // shared setup multiplier
   assign mul_a   = (cmd.op == msgs_pkg::OP_MULY) ? coef_y : coef_x;
   assign mul_b   = (cmd.op == msgs_pkg::OP_MULY) ? {y_ff, 1'b1} : {x0_ff, 1'b1};
   assign product = M_W'(mul_a * $signed({1'b0, mul_b}));

   // clamp to [0, 1] and round to q1.16
   always_comb begin
      above  = !t_ff[T_W-1] && ((|t_ff[T_W-2:30]) || (t_ff[29] && (|t_ff[28:0])));
      if (t_ff[T_W-1]) begin
         t_cl = 30'd0;
      end else if (above) begin
         t_cl = 30'h2000_0000;
      end else begin
         t_cl = t_ff[29:0];
      end
      t16_in = 17'((t_cl + 30'd4096) >> 13);
   end

   // stop search over the entry read this cycle
   assign r_pos   = ram_rdata[msgs_pkg::ENT_W-1:msgs_pkg::COL_W];
   assign r_col   = ram_rdata[msgs_pkg::COL_W-1:0];
   assign hit     = (t16_ff < msgs_pkg::ONE_Q16) && (r_pos >= t16_ff);
   assign at_last = (idx_ff == last_idx);

   always_comb begin
      priority if (cmd.op == msgs_pkg::OP_CLAMP) begin
         idx_in = '0;
      end else if ((cmd.op == msgs_pkg::OP_SCAN) && !hit && !at_last) begin
         idx_in = idx_ff + AW'(1);
      end else begin
         idx_in = idx_ff;
      end
   end
   assign ram_raddr = idx_in;

   // restoring divider step
   assign div_ge = rem_ff >= {1'b0, den_ff};

   // per channel blend in q8.16
   always_comb begin
      logic [7:0]         l, r;
      logic signed [9:0]  dif;
      logic signed [27:0] term, sum;
      for (int k = 0; k < 4; k++) begin
         l        = cl_ff[24-8*k +: 8];
         r        = cr_ff[24-8*k +: 8];
         dif      = $signed({2'b00, r}) - $signed({2'b00, l});
         term     = 28'(dif * $signed({1'b0, w_ff}));
         sum      = $signed({4'b0000, l, 16'h0000}) + term;
         ch_in[k] = sum[23:0];
      end
   end

   // premultiply and round, divide by 255 via reciprocal
   always_comb begin
      logic [48:0] xs;
      logic [17:0] yq;
      pix_in[31:24] = 8'(({1'b0, ch_ff[0]} + 25'd32768) >> 16);
      for (int k = 0; k < 3; k++) begin
         xs = {1'b0, prod_ff[k]} + (49'd255 << 31);
         yq = {1'b0, xs[48:32]};
         pix_in[16-8*k +: 8] = 8'((yq + (yq >> 8) + 18'd1) >> 8);
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = (cmd.op == msgs_pkg::OP_EMIT) && out_free;

   // status to the controller
   assign status.scan_done = hit || at_last;
   assign status.scan_div  = hit && (idx_ff != '0);
   assign status.div_done  = (step_ff == 5'd1);
   assign status.out_free  = out_free;
   assign status.span_end  = (cnt_ff == 7'd1);

   // datapath registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      unique case (cmd.op)
         msgs_pkg::OP_SPAN: begin
            x0_ff  <= req_pixel_x;
            y_ff   <= req_pixel_y;
            cnt_ff <= len_sat;
            t_ff   <= T_W'(coef_offset) <<< 1;
         end
         msgs_pkg::OP_MULY: begin
            mul_ff <= product;
         end
         msgs_pkg::OP_MULX: begin
            t_ff   <= t_ff + T_W'(mul_ff);
            mul_ff <= product;
         end
         msgs_pkg::OP_ACCX: begin
            t_ff <= t_ff + T_W'(mul_ff);
         end
         msgs_pkg::OP_CLAMP: begin
            t16_ff <= t16_in;
         end
         msgs_pkg::OP_SCAN: begin
            w_ff <= '0;
            if (hit && (idx_ff != '0)) begin
               cl_ff   <= prev_col_ff;
               cr_ff   <= r_col;
               den_ff  <= r_pos - prev_pos_ff;
               rem_ff  <= {1'b0, t16_ff - prev_pos_ff};
               step_ff <= 5'(msgs_pkg::DIV_STEPS);
            end else if (hit || at_last) begin
               cl_ff <= r_col;
               cr_ff <= r_col;
            end else begin
               prev_pos_ff <= r_pos;
               prev_col_ff <= r_col;
            end
         end
         msgs_pkg::OP_DIV: begin
            w_ff    <= {w_ff[msgs_pkg::W_W-2:0], div_ge};
            rem_ff  <= (div_ge ? (rem_ff - {1'b0, den_ff}) : rem_ff) << 1;
            step_ff <= step_ff - 5'd1;
         end
         msgs_pkg::OP_MIX: begin
            ch_ff <= ch_in;
         end
         msgs_pkg::OP_PROD: begin
            for (int k = 0; k < 3; k++) begin
               prod_ff[k] <= ch_ff[k+1] * ch_ff[0];
            end
         end
         msgs_pkg::OP_EMIT: begin
            if (out_free) begin
               cnt_ff <= cnt_ff - 7'd1;
               t_ff   <= t_ff + (T_W'(coef_x) <<< 1);
            end
         end
         default: begin
         end
      endcase
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit) begin
         rsp_pixel_ff <= pix_in;
         rsp_last_ff  <= (cnt_ff == 7'd1);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel = rsp_pixel_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

[src/multi_stop_gradient_span_shader_core.sv]
// Multi-stop linear gradient span shader.
// Input channel (req_*): a word is either a stop load (req_kind 1), which
// writes one stop position and colour and gives no output, or a span
// (req_kind 0) of req_span_length pixels starting at (req_pixel_x, req_pixel_y).
// Output channel (rsp_*): one premultiplied ARGB word per pixel, rsp_last on
// the final pixel of the span. Gradient coefficients and the stop count sit
// on the csr_* port; the user must see that they are written only while the
// block is idle, as the block does not enforce it. A span runs its setup
// (multiply by y, by x, accumulate), then per pixel clamps, scans the stops
// one entry a cycle from the stop memory, runs the weight divider (one
// quotient bit a cycle) when the pixel lies between two stops, then blends,
// premultiplies and emits. req_ready is high only between spans; a span is
// taken whole before the next word. The finished pixel sits in an output
// register: when the receiver stalls the block holds at that pixel until
// the word is taken. Reset clears the control state, the output valid flag
// and the csr registers; stop entries are undefined until loaded.
module multi_stop_gradient_span_shader_core #(
   parameter int MAX_STOPS  = msgs_pkg::MAX_STOPS,
   parameter int MAX_SPAN   = msgs_pkg::MAX_SPAN,
   parameter int COORD_BITS = msgs_pkg::COORD_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [COORD_BITS-1:0] req_pixel_x,
   input  logic [COORD_BITS-1:0] req_pixel_y,
   input  logic [6:0]            req_span_length,
   input  logic [2:0]            req_stop_index,
   input  logic [16:0]           req_stop_position,
   input  logic [7:0]            req_stop_red,
   input  logic [7:0]            req_stop_green,
   input  logic [7:0]            req_stop_blue,
   input  logic [7:0]            req_stop_alpha,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [31:0]           rsp_pixel,
   output logic                  rsp_last,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [4:0]            csr_paddr,
   input  logic [63:0]           csr_pwdata,
   output logic [63:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int AW = $clog2(MAX_STOPS > 1 ? MAX_STOPS : 2);

   localparam logic [1:0] REG_COEF_X      = 2'd0;
   localparam logic [1:0] REG_COEF_Y      = 2'd1;
   localparam logic [1:0] REG_COEF_OFFSET = 2'd2;
   localparam logic [1:0] REG_STOP_COUNT  = 2'd3;

   logic signed [31:0]             coef_x_ff, coef_y_ff;
   logic signed [39:0]             coef_offset_ff;
   logic [3:0]                     stop_count_ff;
   logic                           csr_write;
   logic [1:0]                     csr_index;

   msgs_pkg::cmd_type              cmd;
   msgs_pkg::status_type           status;
   logic                           ram_we;
   logic [AW-1:0]                  ram_waddr, ram_raddr;
   logic [msgs_pkg::ENT_W-1:0]     ram_wdata, ram_rdata;

   // register file
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[4:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_x_ff      <= '0;
         coef_y_ff      <= '0;
         coef_offset_ff <= '0;
         stop_count_ff  <= 4'd2;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_COEF_X:      coef_x_ff      <= csr_pwdata[31:0];
            REG_COEF_Y:      coef_y_ff      <= csr_pwdata[31:0];
            REG_COEF_OFFSET: coef_offset_ff <= csr_pwdata[39:0];
            REG_STOP_COUNT:  stop_count_ff  <= csr_pwdata[3:0];
            default: begin
            end
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (csr_index)
         REG_COEF_X:      csr_prdata = {32'h0, coef_x_ff};
         REG_COEF_Y:      csr_prdata = {32'h0, coef_y_ff};
         REG_COEF_OFFSET: csr_prdata = {24'h0, coef_offset_ff};
         REG_STOP_COUNT:  csr_prdata = {60'h0, stop_count_ff};
         default:         csr_prdata = '0;
      endcase
   end

   msgs_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_kind        (req_kind),
      .req_span_length (req_span_length),
      .status          (status),
      .req_ready       (req_ready),
      .cmd             (cmd)
   );

   msgs_dpath #(
      .MAX_STOPS  (MAX_STOPS),
      .MAX_SPAN   (MAX_SPAN),
      .COORD_BITS (COORD_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_pixel_x       (req_pixel_x),
      .req_pixel_y       (req_pixel_y),
      .req_span_length   (req_span_length),
      .req_stop_index    (req_stop_index),
      .req_stop_position (req_stop_position),
      .req_stop_red      (req_stop_red),
      .req_stop_green    (req_stop_green),
      .req_stop_blue     (req_stop_blue),
      .req_stop_alpha    (req_stop_alpha),
      .coef_x            (coef_x_ff),
      .coef_y            (coef_y_ff),
      .coef_offset       (coef_offset_ff),
      .stop_count        (stop_count_ff),
      .ram_we            (ram_we),
      .ram_waddr         (ram_waddr),
      .ram_wdata         (ram_wdata),
      .ram_raddr         (ram_raddr),
      .ram_rdata         (ram_rdata),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_pixel         (rsp_pixel),
      .rsp_last          (rsp_last)
   );

   // stop entries: position over colour
   msgs_ram #(
      .WIDTH (msgs_pkg::ENT_W),
      .DEPTH (MAX_STOPS)
   ) u_stop_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

[src/msgs_checker.sv]
module msgs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_kind,
   input logic [6:0]  req_span_length,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_pixel,
   input logic        rsp_last,
   input logic        csr_pready
);

   // output register empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output word valid after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("csr_pready low");

   // a span holds the input side
   a_span_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_kind && (req_span_length != 7'd0)) |=> !req_ready)
      else $error("new word taken during a span");

   // the input is ready again in the cycle after a stop load
   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind) |=> req_ready)
      else $error("stop load did not complete");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pixel) && $stable(rsp_last)))
      else $error("stalled output word changed");

endmodule

bind multi_stop_gradient_span_shader_core msgs_checker u_checker (.*);
